### sv/ddgc_pkg.sv
// Shared constants, types and tables of the differential-drive goto controller.
`timescale 1ns / 1ps

package ddgc_pkg;

  // Fixed-point formats and iteration counts.
  localparam int POS_FRAC_BITS = 8;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int CSTEP_W       = $clog2(CORDIC_STEPS);

  localparam int POS_W  = 24;
  localparam int POS_SH = 47 - POS_FRAC_BITS;
  localparam int EX_W   = 26;
  localparam int CW     = 44;
  localparam int ZW     = 34;

  localparam int NUM_W     = 62;
  localparam int DEN_W     = 9;
  localparam int QUO_W     = 48;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032875);
  localparam logic [29:0]          INV_TWO_PI  = 30'd683565276;

  localparam logic signed [POS_W-1:0] RST_POS     = POS_W'(300 << POS_FRAC_BITS);
  localparam logic [ANGLE_BITS-1:0]   RST_HEADING = ANGLE_BITS'(1 << (ANGLE_BITS - 3));

  // Configuration register indexes.
  localparam logic [2:0] CFG_WHEEL_RADIUS    = 3'd0;
  localparam logic [2:0] CFG_BODY_RADIUS     = 3'd1;
  localparam logic [2:0] CFG_FORWARD_SPEED   = 3'd2;
  localparam logic [2:0] CFG_TURN_SPEED      = 3'd3;
  localparam logic [2:0] CFG_ARRIVE_DISTANCE = 3'd4;
  localparam logic [2:0] CFG_ALIGN_THRESHOLD = 3'd5;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic in_load;
    logic pre1;
    logic pre2;
    logic pre3;
    logic go;
    logic mulc;
    logic muls;
    logic pos;
    logic tgt;
    logic sqx;
    logic sqy;
    logic stop;
    logic vec_go;
    logic steer;
    logic out_load;
  } ddgc_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic cordic_busy;
    logic div_busy;
    logic target_valid;
    logic near;
    logic zero;
  } ddgc_sts_t;

  // Arctangent of 2^-i in 32-bit turn fractions.
  function automatic logic [31:0] atan_step(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051D;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517C;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A2F;
      5'd19:   r = 32'h00000517;
      5'd20:   r = 32'h0000028B;
      5'd21:   r = 32'h00000145;
      5'd22:   r = 32'h000000A2;
      5'd23:   r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

### sv/ddgc_cordic.sv
// Shared iterative CORDIC: rotation mode for cos/sin, vectoring mode for atan2.
`timescale 1ns / 1ps

module ddgc_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start_rot,
  input  logic                                start_vec,
  input  logic [31:0]                         angle,
  input  logic signed [ddgc_pkg::EX_W-1:0]    vx,
  input  logic signed [ddgc_pkg::EX_W-1:0]    vy,
  output logic                                busy,
  output logic signed [31:0]                  cos_o,
  output logic signed [31:0]                  sin_o,
  output logic [31:0]                         ang_o
);

  logic signed [ddgc_pkg::CW-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys, sx, sy;
  logic signed [ddgc_pkg::ZW-1:0] z_r, z_nxt, at;
  logic [ddgc_pkg::CSTEP_W-1:0]   cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt, vec_r, vec_nxt, neg_r, neg_nxt;
  logic                           dir, rneg;
  logic [31:0]                    a2;
  logic signed [ddgc_pkg::CW-1:0] xo, yo;

  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;
  assign at   = ddgc_pkg::ZW'({2'b00, ddgc_pkg::atan_step(5'(cnt_r))});
  assign dir  = vec_r ? (y_r < 0) : (z_r >= 0);
  // Fold the left half-plane onto the right one.
  assign rneg = (angle - 32'h4000_0000) < 32'h8000_0000;
  assign a2   = rneg ? angle + 32'h8000_0000 : angle;
  assign sx   = ddgc_pkg::CW'(vx) <<< 16;
  assign sy   = ddgc_pkg::CW'(vy) <<< 16;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    vec_nxt  = vec_r;
    neg_nxt  = neg_r;
    if (start_rot) begin
      x_nxt    = ddgc_pkg::CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = ddgc_pkg::ZW'($signed(a2));
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      vec_nxt  = 1'b0;
      neg_nxt  = rneg;
    end else if (start_vec) begin
      x_nxt    = (vx < 0) ? -sx : sx;
      y_nxt    = (vx < 0) ? -sy : sy;
      z_nxt    = (vx < 0) ? ddgc_pkg::ZW'({2'b00, 32'h8000_0000}) : '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      vec_nxt  = 1'b1;
      neg_nxt  = 1'b0;
    end else if (busy_r) begin
      if (dir) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ddgc_pkg::CSTEP_W'(ddgc_pkg::CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vec_r  <= 1'b0;
      neg_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      vec_r  <= vec_nxt;
      neg_r  <= neg_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign xo    = neg_r ? -x_r : x_r;
  assign yo    = neg_r ? -y_r : y_r;
  assign busy  = busy_r;
  assign cos_o = xo[31:0];
  assign sin_o = yo[31:0];
  assign ang_o = z_r[31:0];

endmodule

### sv/ddgc_div.sv
// Restoring divider, one quotient bit per cycle, keeping the low quotient bits.
`timescale 1ns / 1ps

module ddgc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ddgc_pkg::NUM_W-1:0]       num,
  input  logic [ddgc_pkg::DEN_W-1:0]       den,
  output logic                             busy,
  output logic [ddgc_pkg::QUO_W-1:0]       quo
);

  logic [ddgc_pkg::NUM_W-1:0]     num_r;
  logic [ddgc_pkg::DEN_W-1:0]     den_r, rem_r;
  logic [ddgc_pkg::QUO_W-1:0]     q_r;
  logic [ddgc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic [ddgc_pkg::DEN_W:0]       rs, dif;
  logic                           ge;

  assign rs  = {rem_r, num_r[ddgc_pkg::NUM_W-1]};
  assign dif = rs - {1'b0, den_r};
  assign ge  = rs >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == ddgc_pkg::DIV_CNT_W'(ddgc_pkg::NUM_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[ddgc_pkg::NUM_W-2:0], 1'b0};
      rem_r <= ge ? dif[ddgc_pkg::DEN_W-1:0] : rs[ddgc_pkg::DEN_W-1:0];
      q_r   <= {q_r[ddgc_pkg::QUO_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

### sv/ddgc_datapath.sv
// Datapath: configuration, pose state, multipliers, CORDIC, divider and steering.
`timescale 1ns / 1ps

module ddgc_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ddgc_pkg::ddgc_cmd_t    cmd,
  output ddgc_pkg::ddgc_sts_t    sts,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_addr,
  input  logic [15:0]            cfg_wdata,
  input  logic [39:0]            in_tdata,
  input  logic                   in_tuser,
  output logic [79:0]            out_tdata,
  output logic                   out_tuser
);

  localparam int F  = ddgc_pkg::POS_FRAC_BITS;
  localparam int AB = ddgc_pkg::ANGLE_BITS;

  function automatic logic signed [ddgc_pkg::POS_W-1:0] sat_pos(input logic signed [63:0] v);
    logic signed [63:0] mx, mn;
    mx = 64'sd8388607;
    mn = -64'sd8388608;
    if (v > mx) return ddgc_pkg::POS_W'(mx);
    if (v < mn) return ddgc_pkg::POS_W'(mn);
    return ddgc_pkg::POS_W'(v);
  endfunction

  // Configuration.
  logic [7:0]  wr_r, br_r, ad_r;
  logic [5:0]  fs_r, ts_r;
  logic [15:0] th_r;

  // Input beat.
  logic [15:0] dt_r;
  logic [9:0]  tx_r, ty_r;
  logic        tv_r;

  // Block state.
  logic signed [ddgc_pkg::POS_W-1:0] px_r, py_r;
  logic [AB-1:0]                     hd_r;
  logic signed [6:0]                 lw_r, rw_r;
  logic                              arr_r;

  // Work registers.
  logic [23:0]                      dtr_r;
  logic signed [32:0]               prod_r;
  logic [30:0]                      hm_r;
  logic [60:0]                      mag_r;
  logic signed [63:0]               pc_r, ps_r;
  logic signed [ddgc_pkg::EX_W-1:0] ex_r, ey_r;
  logic [51:0]                      sq_r, d2_r;

  // Result register.
  logic [79:0] od_r;
  logic        ou_r;

  logic signed [7:0]   sum, diff;
  logic [6:0]          absd;
  logic signed [32:0]  prod_w;
  logic [7:0]          bb;
  logic                cbusy, dbusy;
  logic signed [31:0]  cos_w, sin_w;
  logic [31:0]         ang_w, h32;
  logic [ddgc_pkg::QUO_W-1:0] quo_w, rq;
  logic [AB-1:0]       units;
  logic signed [63:0]  rnd, dx, dy;
  logic signed [ddgc_pkg::EX_W-1:0] ex_w, ey_w;
  logic signed [51:0]  sqa, sqb;
  logic [8+F-1:0]      lim;
  logic [2*(8+F)-1:0]  limsq;
  logic [31:0]         dir, dd, err;
  logic [32:0]         f1;
  logic signed [33:0]  f2, v1, v2;
  logic                cw, fwd;

  assign sum    = 8'(lw_r) + 8'(rw_r);
  assign diff   = 8'(rw_r) - 8'(lw_r);
  assign absd   = 7'(diff < 0 ? -diff : diff);
  assign prod_w = $signed({1'b0, dtr_r}) * sum;
  assign bb     = (br_r == 8'd0) ? 8'd1 : br_r;
  assign h32    = {hd_r, {(32 - AB){1'b0}}};

  ddgc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_rot (cmd.go),
    .start_vec (cmd.vec_go),
    .angle     (h32),
    .vx        (ex_r),
    .vy        (ey_r),
    .busy      (cbusy),
    .cos_o     (cos_w),
    .sin_o     (sin_w),
    .ang_o     (ang_w)
  );

  ddgc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.go),
    .num   ({1'b0, mag_r} + ddgc_pkg::NUM_W'(bb)),
    .den   ({1'b0, bb} << 1),
    .busy  (dbusy),
    .quo   (quo_w)
  );

  // Rounded heading step from the quotient.
  assign rq    = quo_w + (ddgc_pkg::QUO_W'(1) << (47 - AB));
  assign units = rq[47 -: AB];

  // Rounded position steps.
  assign rnd = 64'sd1 <<< (ddgc_pkg::POS_SH - 1);
  assign dx  = (pc_r + rnd) >>> ddgc_pkg::POS_SH;
  assign dy  = (ps_r + rnd) >>> ddgc_pkg::POS_SH;

  // Offset to the target with y pointing up.
  assign ex_w = ddgc_pkg::EX_W'($signed({1'b0, tx_r, {F{1'b0}}})) - ddgc_pkg::EX_W'(px_r);
  assign ey_w = ddgc_pkg::EX_W'(py_r) - ddgc_pkg::EX_W'($signed({1'b0, ty_r, {F{1'b0}}}));
  assign sqa  = ex_r * ex_r;
  assign sqb  = ey_r * ey_r;
  assign lim  = {ad_r, {F{1'b0}}};
  assign limsq = lim * lim;

  // Steering decision.
  assign dir = sts.zero ? h32 : ang_w;
  assign dd  = dir - h32;
  assign err = (dd <= 32'h8000_0000) ? dd : (32'h0 - dd);

  always_comb begin
    f1 = {1'b0, h32} + {1'b0, err};
    if (f1 > 33'h1_0000_0000) begin
      f1 = f1 - 33'h1_0000_0000;
    end
    f2 = $signed({2'b00, h32}) - $signed({2'b00, err});
    if (f2 < 0) begin
      f2 = f2 + 34'sh1_0000_0000;
    end
    v1 = $signed({1'b0, f1}) - $signed({2'b00, dir});
    if (v1 < 0) begin
      v1 = -v1;
    end
    v2 = f2 - $signed({2'b00, dir});
    if (v2 < 0) begin
      v2 = -v2;
    end
  end

  assign cw  = v2 < v1;
  assign fwd = err < {th_r, 16'h0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 8'd10;
      br_r  <= 8'd25;
      fs_r  <= 6'd6;
      ts_r  <= 6'd5;
      ad_r  <= 8'd5;
      th_r  <= 16'd626;
      px_r  <= ddgc_pkg::RST_POS;
      py_r  <= ddgc_pkg::RST_POS;
      hd_r  <= ddgc_pkg::RST_HEADING;
      lw_r  <= '0;
      rw_r  <= '0;
      arr_r <= 1'b0;
      tv_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ddgc_pkg::CFG_WHEEL_RADIUS:    wr_r <= cfg_wdata[7:0];
          ddgc_pkg::CFG_BODY_RADIUS:     br_r <= cfg_wdata[7:0];
          ddgc_pkg::CFG_FORWARD_SPEED:   fs_r <= cfg_wdata[5:0];
          ddgc_pkg::CFG_TURN_SPEED:      ts_r <= cfg_wdata[5:0];
          ddgc_pkg::CFG_ARRIVE_DISTANCE: ad_r <= cfg_wdata[7:0];
          ddgc_pkg::CFG_ALIGN_THRESHOLD: th_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.in_load) begin
        tv_r  <= in_tuser;
        arr_r <= 1'b0;
      end
      if (cmd.pos) begin
        px_r <= sat_pos(64'(px_r) + dx);
        py_r <= sat_pos(64'(py_r) - dy);
        hd_r <= (diff < 0) ? hd_r - units : hd_r + units;
      end
      if (cmd.stop) begin
        lw_r  <= '0;
        rw_r  <= '0;
        arr_r <= 1'b1;
      end
      if (cmd.steer) begin
        if (fwd) begin
          lw_r <= $signed({1'b0, fs_r});
          rw_r <= $signed({1'b0, fs_r});
        end else if (cw) begin
          lw_r <= $signed({1'b0, ts_r});
          rw_r <= -$signed({1'b0, ts_r});
        end else begin
          lw_r <= -$signed({1'b0, ts_r});
          rw_r <= $signed({1'b0, ts_r});
        end
      end
    end
    if (cmd.in_load) begin
      dt_r <= in_tdata[15:0];
      tx_r <= in_tdata[25:16];
      ty_r <= in_tdata[35:26];
    end
    if (cmd.pre1) dtr_r <= dt_r * wr_r;
    if (cmd.pre2) begin
      prod_r <= prod_w;
      hm_r   <= dtr_r * absd;
    end
    if (cmd.pre3) mag_r <= hm_r * ddgc_pkg::INV_TWO_PI;
    if (cmd.mulc) pc_r <= prod_r * cos_w;
    if (cmd.muls) ps_r <= prod_r * sin_w;
    if (cmd.tgt) begin
      ex_r <= ex_w;
      ey_r <= ey_w;
    end
    if (cmd.sqx) sq_r <= 52'(sqa);
    if (cmd.sqy) d2_r <= sq_r + 52'(sqb);
    if (cmd.out_load) begin
      od_r <= {2'b00, h32[31:16], py_r, px_r, rw_r, lw_r};
      ou_r <= arr_r;
    end
  end

  assign sts.cordic_busy  = cbusy;
  assign sts.div_busy     = dbusy;
  assign sts.target_valid = tv_r;
  assign sts.near         = d2_r < 52'(limsq);
  assign sts.zero         = (ex_r == 0) && (ey_r == 0);

  assign out_tdata = od_r;
  assign out_tuser = ou_r;

endmodule

### sv/ddgc_ctrl.sv
// Sequencer state machine and output handshake of the goto controller.
`timescale 1ns / 1ps

module ddgc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  ddgc_pkg::ddgc_sts_t   sts,
  output ddgc_pkg::ddgc_cmd_t   cmd
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_PRE1  = 16'h0002,
    S_PRE2  = 16'h0004,
    S_PRE3  = 16'h0008,
    S_GO    = 16'h0010,
    S_WAIT  = 16'h0020,
    S_MULC  = 16'h0040,
    S_MULS  = 16'h0080,
    S_POS   = 16'h0100,
    S_TGT   = 16'h0200,
    S_SQX   = 16'h0400,
    S_SQY   = 16'h0800,
    S_CMP   = 16'h1000,
    S_VWAIT = 16'h2000,
    S_STEER = 16'h4000,
    S_OUT   = 16'h8000
  } ddgc_state_t;

  ddgc_state_t state_r, state_nxt;
  logic        ov_r, ov_nxt;
  logic        load;

  assign load = (state_r == S_OUT) && (!ov_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_PRE1;
      S_PRE1:  state_nxt = S_PRE2;
      S_PRE2:  state_nxt = S_PRE3;
      S_PRE3:  state_nxt = S_GO;
      S_GO:    state_nxt = S_WAIT;
      S_WAIT:  if (!sts.cordic_busy && !sts.div_busy) state_nxt = S_MULC;
      S_MULC:  state_nxt = S_MULS;
      S_MULS:  state_nxt = S_POS;
      S_POS:   state_nxt = sts.target_valid ? S_TGT : S_OUT;
      S_TGT:   state_nxt = S_SQX;
      S_SQX:   state_nxt = S_SQY;
      S_SQY:   state_nxt = S_CMP;
      S_CMP: begin
        if (sts.near) state_nxt = S_OUT;
        else if (sts.zero) state_nxt = S_STEER;
        else state_nxt = S_VWAIT;
      end
      S_VWAIT: if (!sts.cordic_busy) state_nxt = S_STEER;
      S_STEER: state_nxt = S_OUT;
      S_OUT:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load) ov_nxt = 1'b1;
    else if (out_tready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;

  assign cmd.in_load  = (state_r == S_IDLE) && in_tvalid;
  assign cmd.pre1     = (state_r == S_PRE1);
  assign cmd.pre2     = (state_r == S_PRE2);
  assign cmd.pre3     = (state_r == S_PRE3);
  assign cmd.go       = (state_r == S_GO);
  assign cmd.mulc     = (state_r == S_MULC);
  assign cmd.muls     = (state_r == S_MULS);
  assign cmd.pos      = (state_r == S_POS);
  assign cmd.tgt      = (state_r == S_TGT);
  assign cmd.sqx      = (state_r == S_SQX);
  assign cmd.sqy      = (state_r == S_SQY);
  assign cmd.stop     = (state_r == S_CMP) && sts.near;
  assign cmd.vec_go   = (state_r == S_CMP) && !sts.near && !sts.zero;
  assign cmd.steer    = (state_r == S_STEER);
  assign cmd.out_load = load;

endmodule

### sv/diff_drive_goto_controller.sv
// Top level of the differential-drive goto controller.
`timescale 1ns / 1ps

// Each input beat is one display frame. The block first advances the robot
// pose over frame_time seconds with the wheel speeds it holds, then, when a
// target is flagged in in_tuser, picks new wheel speeds: stop inside the
// arrival distance, otherwise turn toward the target and drive forward once
// the heading error is below the alignment threshold. One result beat comes
// out per input beat. Items are handled one at a time. The processing time
// is set by the bit-serial heading divider, run alongside the 16-step cosine
// and sine CORDIC, and, with a target that is neither reached nor on the
// robot, by a second 16-step CORDIC pass for the target direction. A finished
// result that must wait because the previous one is still held and out_tready
// is low stalls the block until it is loaded. The next input beat is taken
// while a finished result still waits in the output register. Configuration
// is written through a plain write port; the user must write it only while
// the block is idle, and the block itself has no guard for this. It holds
// its values from reset until rewritten.
module diff_drive_goto_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // frame_time[15:0], target_x[25:16], target_y[35:26], zero fill
  input  logic [39:0] in_tdata,
  // target_valid
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_wheel_speed[6:0], right_wheel_speed[13:7], position_x[37:14],
  // position_y[61:38], heading_out[77:62], zero fill
  output logic [79:0] out_tdata,
  // arrived
  output logic        out_tuser
);

  ddgc_pkg::ddgc_cmd_t cmd;
  ddgc_pkg::ddgc_sts_t sts;

  ddgc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ddgc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

`ifndef SYNTH
  // Once a beat is taken the block is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // An arrival always reports both wheels stopped.
  a_arrive_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[13:0] == 14'h0)
    else $error("arrived with nonzero wheel speed");

  // Wheel speeds never reach the unused code -64.
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] != 7'h40 && out_tdata[13:7] != 7'h40)
    else $error("wheel speed out of range");
`endif

endmodule
